// ----- hw/rtl/mwo_pkg.sv -----
package mwo_pkg;

    localparam int CELL_W    = 12;
    localparam int CELLS     = 4096;
    localparam int LINK_W    = 13;
    localparam int SIZE_W    = 13;
    localparam int SIDE_W    = 7;
    localparam int MAX_SIDE  = 64;

    localparam logic [LINK_W-1:0] LINK_END = 13'h1000;

    localparam logic [1:0] WALL_CLOSED = 2'd0;
    localparam logic [1:0] WALL_OPEN   = 2'd1;
    localparam logic [1:0] WALL_BOUND  = 2'd2;

    localparam logic WALL_EAST  = 1'b0;
    localparam logic WALL_NORTH = 1'b1;

    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_OPEN  = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    localparam logic REG_GRID_WIDTH  = 1'b0;
    localparam logic REG_GRID_HEIGHT = 1'b1;

    typedef struct packed {
        logic [1:0]        mode;
        logic [CELL_W-1:0] cell_req;
        logic              first_wall;
    } req_t;

    typedef struct packed {
        logic              opened;
        logic              opened_wall;
        logic [CELL_W-1:0] openings_remaining;
        logic              complete;
        logic [1:0]        north_state;
        logic [1:0]        east_state;
        logic [CELL_W-1:0] set_label;
        logic              bad_cell;
    } rsp_t;

    typedef struct packed {
        logic [CELL_W-1:0] set;
        logic [1:0]        north;
        logic [1:0]        east;
        logic [LINK_W-1:0] link;
    } cell_entry_t;

    typedef struct packed {
        logic [SIZE_W-1:0] size;
        logic [CELL_W-1:0] last;
    } group_entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_MOD,
        ST_GETC,
        ST_TRY,
        ST_CMP,
        ST_SZA,
        ST_SZB,
        ST_WALK,
        ST_LINK,
        ST_LINKW,
        ST_FIN,
        ST_FIN2,
        ST_OUT
    } state_t;

endpackage

// ----- hw/rtl/mwo_mod.sv -----
module mwo_mod
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [mwo_pkg::CELL_W-1:0]    dividend,
    input  logic [mwo_pkg::SIDE_W-1:0]    divisor,
    output logic                          done,
    output logic [mwo_pkg::SIDE_W-1:0]    rem
);

    logic                        busy_reg;
    logic                        done_reg;
    logic [3:0]                  cnt_reg;
    logic [mwo_pkg::CELL_W-1:0]  dvd_reg;
    logic [mwo_pkg::SIDE_W-1:0]  rem_reg;
    logic [mwo_pkg::SIDE_W-1:0]  div_reg;
    logic [mwo_pkg::SIDE_W:0]    trial;
    logic [mwo_pkg::SIDE_W-1:0]  rem_next;

    // One quotient bit per cycle, restoring form.
    always_comb
    begin
        trial = {rem_reg, dvd_reg[mwo_pkg::CELL_W-1]};
        if (trial >= {1'b0, div_reg})
        begin
            rem_next = mwo_pkg::SIDE_W'(trial - {1'b0, div_reg});
        end
        else
        begin
            rem_next = trial[mwo_pkg::SIDE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 4'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 4'(mwo_pkg::CELL_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 4'd1;
                if (cnt_reg == 4'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            div_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[mwo_pkg::CELL_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

// ----- hw/rtl/maze_wall_opener_set_merge.sv -----
// Maze builder that joins cell sets as walls open, on a grid of up to 64 by 64 cells, with one
// result per request. A start request sweeps the cell and group memories one cell per cycle.
// An open request first waits for the column of the cell from a bit-serial remainder unit.
// It then tests up to two walls through the one read port of the cell memory and, when a
// wall opens, relabels the smaller set one cell per cycle. A request is accepted only when
// the previous one has finished, while its result may still be waiting at the output register.
module maze_wall_opener_set_merge
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  mwo_pkg::req_t        req,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output mwo_pkg::rsp_t        rsp,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int CW = mwo_pkg::CELL_W;
    localparam int SW = mwo_pkg::SIDE_W;

    logic [SW-1:0] width_reg;
    logic [SW-1:0] height_reg;

    mwo_pkg::cell_entry_t  cell_mem [mwo_pkg::CELLS];
    mwo_pkg::group_entry_t group_mem [mwo_pkg::CELLS];

    logic                  cell_we;
    logic [CW-1:0]         cell_waddr;
    mwo_pkg::cell_entry_t  cell_wdata;
    logic [CW-1:0]         cell_raddr;
    mwo_pkg::cell_entry_t  cell_rdata;
    logic                  group_we;
    logic [CW-1:0]         group_waddr;
    mwo_pkg::group_entry_t group_wdata;
    logic [CW-1:0]         group_raddr;
    mwo_pkg::group_entry_t group_rdata;

    mwo_pkg::state_t       state_reg, state_next;
    mwo_pkg::req_t         op_reg, op_next;
    logic [CW-1:0]         idx_reg, idx_next;
    logic [SW-1:0]         col_reg, col_next;
    logic                  wall_reg, wall_next;
    logic                  tried_reg, tried_next;
    mwo_pkg::cell_entry_t  cent_reg, cent_next;
    logic [CW-1:0]         bset_reg, bset_next;
    logic [mwo_pkg::SIZE_W-1:0] size_a_reg, size_a_next;
    logic [CW-1:0]         last_a_reg, last_a_next;
    logic [CW-1:0]         keep_reg, keep_next;
    logic [CW-1:0]         gone_reg, gone_next;
    logic [CW-1:0]         tail_reg, tail_next;
    logic [CW-1:0]         walls_left_reg, walls_left_next;
    mwo_pkg::rsp_t         res_reg, res_next;
    mwo_pkg::rsp_t         rsp_reg, rsp_next;
    logic                  rsp_valid_reg, rsp_valid_next;

    logic                  mod_start;
    logic                  mod_done;
    logic [SW-1:0]         mod_rem;

    logic [SW-1:0]         w_eff;
    logic [SW-1:0]         h_eff;
    logic [2*SW-1:0]       cells_prod;
    logic [CW:0]           n_cells;
    logic [CW-1:0]         c;
    logic                  legal;
    logic [CW-1:0]         nb;
    logic                  fail;

    function automatic logic [SW-1:0] clamp_side(input logic [SW-1:0] v);
        logic [SW-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = SW'(1);
        end
        else if (v > SW'(mwo_pkg::MAX_SIDE))
        begin
            r = SW'(mwo_pkg::MAX_SIDE);
        end
        return r;
    endfunction

    assign w_eff      = clamp_side(width_reg);
    assign h_eff      = clamp_side(height_reg);
    assign cells_prod = w_eff * h_eff;
    assign n_cells    = cells_prod[CW:0];
    assign c          = op_reg.cell_req;

    // Configuration port.
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= SW'(8);
            height_reg <= SW'(8);
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[2])
                mwo_pkg::REG_GRID_WIDTH:  width_reg  <= pwdata[SW-1:0];
                mwo_pkg::REG_GRID_HEIGHT: height_reg <= pwdata[SW-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            mwo_pkg::REG_GRID_WIDTH:  prdata = {{(32-SW){1'b0}}, width_reg};
            mwo_pkg::REG_GRID_HEIGHT: prdata = {{(32-SW){1'b0}}, height_reg};
            default:                  prdata = '0;
        endcase
    end

    // Memories.
    always_ff @(posedge clk)
    begin
        if (cell_we)
        begin
            cell_mem[cell_waddr] <= cell_wdata;
        end
        cell_rdata <= cell_mem[cell_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (group_we)
        begin
            group_mem[group_waddr] <= group_wdata;
        end
        group_rdata <= group_mem[group_raddr];
    end

    mwo_mod u_mod
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (op_reg.cell_req),
        .divisor  (w_eff),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    // Wall test for the wall currently selected.
    always_comb
    begin
        if (wall_reg == mwo_pkg::WALL_NORTH)
        begin
            nb    = c - {{(CW-SW){1'b0}}, w_eff};
            legal = (c >= {{(CW-SW){1'b0}}, w_eff}) &&
                    (cent_reg.north == mwo_pkg::WALL_CLOSED);
        end
        else
        begin
            nb    = c + CW'(1);
            legal = (col_reg != w_eff - SW'(1)) &&
                    (({1'b0, c} + (CW+1)'(1)) < n_cells) &&
                    (cent_reg.east == mwo_pkg::WALL_CLOSED);
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        idx_next        = idx_reg;
        col_next        = col_reg;
        wall_next       = wall_reg;
        tried_next      = tried_reg;
        cent_next       = cent_reg;
        bset_next       = bset_reg;
        size_a_next     = size_a_reg;
        last_a_next     = last_a_reg;
        keep_next       = keep_reg;
        gone_next       = gone_reg;
        tail_next       = tail_reg;
        walls_left_next = walls_left_reg;
        res_next        = res_reg;
        rsp_next        = rsp_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        mod_start       = 1'b0;
        fail            = 1'b0;
        cell_we         = 1'b0;
        cell_waddr      = idx_reg;
        cell_wdata      = cent_reg;
        cell_raddr      = c;
        group_we        = 1'b0;
        group_waddr     = idx_reg;
        group_wdata     = '0;
        group_raddr     = cent_reg.set;
        req_stall       = (state_reg != mwo_pkg::ST_IDLE);

        case (state_reg)
            mwo_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    op_next    = req;
                    res_next   = '0;
                    idx_next   = '0;
                    col_next   = '0;
                    wall_next  = req.first_wall;
                    tried_next = 1'b0;
                    case (req.mode)
                        mwo_pkg::MODE_START:
                        begin
                            state_next = mwo_pkg::ST_CLEAR;
                        end
                        mwo_pkg::MODE_OPEN, mwo_pkg::MODE_READ:
                        begin
                            if ({1'b0, req.cell_req} >= n_cells)
                            begin
                                res_next.bad_cell = 1'b1;
                                state_next        = mwo_pkg::ST_OUT;
                            end
                            else if (req.mode == mwo_pkg::MODE_OPEN)
                            begin
                                state_next = mwo_pkg::ST_MOD;
                            end
                            else
                            begin
                                state_next = mwo_pkg::ST_FIN;
                            end
                        end
                        default:
                        begin
                            state_next = mwo_pkg::ST_OUT;
                        end
                    endcase
                end
            end

            mwo_pkg::ST_CLEAR:
            begin
                cell_we          = 1'b1;
                cell_waddr       = idx_reg;
                cell_wdata.set   = idx_reg;
                cell_wdata.north = (idx_reg < {{(CW-SW){1'b0}}, w_eff}) ?
                                   mwo_pkg::WALL_BOUND : mwo_pkg::WALL_CLOSED;
                cell_wdata.east  = (col_reg == w_eff - SW'(1)) ?
                                   mwo_pkg::WALL_BOUND : mwo_pkg::WALL_CLOSED;
                cell_wdata.link  = mwo_pkg::LINK_END;
                group_we         = 1'b1;
                group_waddr      = idx_reg;
                group_wdata.size = mwo_pkg::SIZE_W'(1);
                group_wdata.last = idx_reg;
                col_next = (col_reg == w_eff - SW'(1)) ? '0 : col_reg + SW'(1);
                idx_next = idx_reg + CW'(1);
                if ({1'b0, idx_reg} == n_cells - (CW+1)'(1))
                begin
                    walls_left_next = idx_reg;
                    state_next      = mwo_pkg::ST_OUT;
                end
            end

            mwo_pkg::ST_MOD:
            begin
                mod_start = (idx_reg == '0);
                idx_next  = CW'(1);
                if (mod_done)
                begin
                    col_next   = mod_rem;
                    state_next = mwo_pkg::ST_GETC;
                end
            end

            mwo_pkg::ST_GETC:
            begin
                cent_next  = cell_rdata;
                state_next = mwo_pkg::ST_TRY;
            end

            mwo_pkg::ST_TRY:
            begin
                if (legal)
                begin
                    cell_raddr = nb;
                    state_next = mwo_pkg::ST_CMP;
                end
                else
                begin
                    fail = 1'b1;
                end
            end

            mwo_pkg::ST_CMP:
            begin
                if (cell_rdata.set == cent_reg.set)
                begin
                    fail = 1'b1;
                end
                else
                begin
                    cell_we    = 1'b1;
                    cell_waddr = c;
                    cell_wdata = cent_reg;
                    if (wall_reg == mwo_pkg::WALL_NORTH)
                    begin
                        cell_wdata.north = mwo_pkg::WALL_OPEN;
                    end
                    else
                    begin
                        cell_wdata.east = mwo_pkg::WALL_OPEN;
                    end
                    cent_next            = cell_wdata;
                    bset_next            = cell_rdata.set;
                    res_next.opened      = 1'b1;
                    res_next.opened_wall = wall_reg;
                    if (walls_left_reg != '0)
                    begin
                        walls_left_next = walls_left_reg - CW'(1);
                    end
                    group_raddr = cent_reg.set;
                    state_next  = mwo_pkg::ST_SZA;
                end
            end

            mwo_pkg::ST_SZA:
            begin
                size_a_next = group_rdata.size;
                last_a_next = group_rdata.last;
                group_raddr = bset_reg;
                state_next  = mwo_pkg::ST_SZB;
            end

            mwo_pkg::ST_SZB:
            begin
                group_we         = 1'b1;
                group_wdata.size = size_a_reg + group_rdata.size;
                if (size_a_reg > group_rdata.size)
                begin
                    keep_next        = cent_reg.set;
                    gone_next        = bset_reg;
                    tail_next        = last_a_reg;
                    group_waddr      = cent_reg.set;
                    group_wdata.last = group_rdata.last;
                    cell_raddr       = bset_reg;
                    idx_next         = bset_reg;
                end
                else
                begin
                    keep_next        = bset_reg;
                    gone_next        = cent_reg.set;
                    tail_next        = group_rdata.last;
                    group_waddr      = bset_reg;
                    group_wdata.last = last_a_reg;
                    cell_raddr       = cent_reg.set;
                    idx_next         = cent_reg.set;
                end
                state_next = mwo_pkg::ST_WALK;
            end

            mwo_pkg::ST_WALK:
            begin
                cell_we        = 1'b1;
                cell_waddr     = idx_reg;
                cell_wdata     = cell_rdata;
                cell_wdata.set = keep_reg;
                if (cell_rdata.link == mwo_pkg::LINK_END)
                begin
                    state_next = mwo_pkg::ST_LINK;
                end
                else
                begin
                    cell_raddr = cell_rdata.link[CW-1:0];
                    idx_next   = cell_rdata.link[CW-1:0];
                end
            end

            mwo_pkg::ST_LINK:
            begin
                cell_raddr = tail_reg;
                state_next = mwo_pkg::ST_LINKW;
            end

            mwo_pkg::ST_LINKW:
            begin
                cell_we         = 1'b1;
                cell_waddr      = tail_reg;
                cell_wdata      = cell_rdata;
                cell_wdata.link = {1'b0, gone_reg};
                state_next      = mwo_pkg::ST_FIN;
            end

            mwo_pkg::ST_FIN:
            begin
                state_next = mwo_pkg::ST_FIN2;
            end

            mwo_pkg::ST_FIN2:
            begin
                res_next.north_state = cell_rdata.north;
                res_next.east_state  = cell_rdata.east;
                res_next.set_label   = cell_rdata.set;
                state_next           = mwo_pkg::ST_OUT;
            end

            mwo_pkg::ST_OUT:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next                    = res_reg;
                    rsp_next.openings_remaining = walls_left_reg;
                    rsp_next.complete           = (walls_left_reg == '0);
                    rsp_valid_next              = 1'b1;
                    state_next                  = mwo_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = mwo_pkg::ST_IDLE;
            end
        endcase

        if (fail)
        begin
            if (!tried_reg)
            begin
                wall_next  = ~wall_reg;
                tried_next = 1'b1;
                state_next = mwo_pkg::ST_TRY;
            end
            else
            begin
                state_next = mwo_pkg::ST_FIN;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= mwo_pkg::ST_IDLE;
            walls_left_reg <= '0;
            rsp_valid_reg  <= 1'b0;
            idx_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            walls_left_reg <= walls_left_next;
            rsp_valid_reg  <= rsp_valid_next;
            idx_reg        <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        col_reg    <= col_next;
        wall_reg   <= wall_next;
        tried_reg  <= tried_next;
        cent_reg   <= cent_next;
        bset_reg   <= bset_next;
        size_a_reg <= size_a_next;
        last_a_reg <= last_a_next;
        keep_reg   <= keep_next;
        gone_reg   <= gone_next;
        tail_reg   <= tail_next;
        res_reg    <= res_next;
        rsp_reg    <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // The count of walls still to open only grows when a start request sweeps the grid.
    a_walls_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (walls_left_reg > $past(walls_left_reg)) |-> ($past(state_reg) == mwo_pkg::ST_CLEAR))
        else $error("walls_left grew outside a start sweep");

    // A new response appears only when the sequencer leaves its output state.
    a_rsp_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> ($past(state_reg) == mwo_pkg::ST_OUT))
        else $error("response raised outside the output state");

    // Relabeling happens only after a wall has been opened.
    a_walk_opened: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mwo_pkg::ST_WALK) |-> res_reg.opened)
        else $error("set relabel without an opened wall");

    // The remainder unit only finishes while the sequencer waits for it.
    a_mod_done: assert property (@(posedge clk) disable iff (!rst_n)
        mod_done |-> (state_reg == mwo_pkg::ST_MOD))
        else $error("remainder result arrived outside its wait state");

endmodule
